[rtl/core/kce_pkg.sv]
package kce_pkg;

  localparam int unsigned DIGITS      = 4;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MATRIX_W    = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned VALUE_W     = 14;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 40;

  localparam logic [CODE_W-1:0]    DIGIT_LIMIT   = CODE_W'(10);
  localparam logic [TIME_W-1:0]    LOCKOUT_RESET = TIME_W'(250);
  localparam logic [CODE_W-1:0]    ENTER_RESET   = CODE_W'(15);

  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENTER   = CFG_IDX_W'(1);

  localparam logic [15:0][CODE_W-1:0] KEY_TABLE = {
    4'hD, 4'hF, 4'h0, 4'hE, 4'hC, 4'h9, 4'h8, 4'h7,
    4'hB, 4'h6, 4'h5, 4'h4, 4'hA, 4'h3, 4'h2, 4'h1
  };

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_buf_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now_time;
    logic [MATRIX_W-1:0] key_matrix;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] current_code;
    logic [VALUE_W-1:0] entered_value;
    logic               enter_accepted;
    logic               digit_accepted;
    logic [CODE_W-1:0]  key_code;
    logic               key_present;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } scan_t;

  // Row 0 has priority; within a row the highest column wins.
  function automatic scan_t scan_matrix(input logic [MATRIX_W-1:0] m);
    scan_t s;
    s.hit  = 1'b0;
    s.code = '0;
    for (int row = 3; row >= 0; row--) begin
      for (int col = 0; col < 4; col++) begin
        if (m[4*row+col]) begin
          s.hit  = 1'b1;
          s.code = KEY_TABLE[4*row+col];
        end
      end
    end
    return s;
  endfunction

  // Digit DIGITS-1 is the most significant.
  function automatic logic [VALUE_W-1:0] buffer_value(input digit_buf_t b);
    logic [ACC_W-1:0] v;
    v = '0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      v = ACC_W'(v * ACC_W'(10)) + ACC_W'(b[i]);
    end
    return v[VALUE_W-1:0];
  endfunction

endpackage

[rtl/core/keypad_code_entry.sv]
// Channel  Direction  Handshake              Payload
// in_      request    in_tvalid/in_tready    in_tdata: key_matrix, now_time
// out_     result     out_tvalid/out_tready  out_tdata: key_present .. current_code
// cfg_     write      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request per clock is sustained while the output is not stalled; a result
// passes through the input register and then the result register.
// Synchronous active-low reset clears the buffer, the last press time, both
// configuration registers to their defaults, and all valid flags.
// A stalled output holds the result register; the input side keeps accepting
// until the input register is also full.
module keypad_code_entry (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] key_matrix, [47:16] now_time
  input  logic [kce_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] key_present, [4:1] key_code, [5] digit_accepted, [6] enter_accepted,
  // [20:7] entered_value, [34:21] current_code, [39:35] zero
  output logic [kce_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kce_pkg::*;

  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res;
  logic              advance;
  logic [TIME_W-1:0] lockout_r;
  logic [CODE_W-1:0] enter_key_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r   <= LOCKOUT_RESET;
      enter_key_r <= ENTER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCKOUT: lockout_r   <= cfg_data[TIME_W-1:0];
        REG_ENTER:   enter_key_r <= cfg_data[CODE_W-1:0];
        default:     ;
      endcase
    end
  end

  kce_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .item          (in_item_r),
    .lockout_ticks (lockout_r),
    .enter_key     (enter_key_r),
    .result        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_res_r};

endmodule

[rtl/core/kce_engine.sv]
module kce_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  kce_pkg::in_item_t     item,
  input  logic [31:0]           lockout_ticks,
  input  logic [3:0]            enter_key,
  output kce_pkg::result_t      result
);
  import kce_pkg::*;

  digit_buf_t        digits_r, digits_nxt;
  logic [TIME_W-1:0] last_press_r, last_press_nxt;
  scan_t             hit;
  logic [TIME_W-1:0] elapsed;
  logic              timely;
  logic              is_digit;
  logic              digit_ok;
  logic              enter_ok;

  assign hit      = scan_matrix(item.key_matrix);
  assign elapsed  = item.now_time - last_press_r;
  assign timely   = elapsed > lockout_ticks;
  assign is_digit = hit.code < DIGIT_LIMIT;

  always_comb begin
    digits_nxt     = digits_r;
    last_press_nxt = last_press_r;
    digit_ok       = 1'b0;
    enter_ok       = 1'b0;
    if (hit.hit && is_digit && timely) begin
      if (hit.code != enter_key) begin
        for (int i = DIGITS - 1; i > 0; i--) begin
          digits_nxt[i] = digits_r[i-1];
        end
        digits_nxt[0] = hit.code;
        digit_ok      = 1'b1;
      end
      last_press_nxt = item.now_time;
    end else if (hit.hit && hit.code == enter_key && timely) begin
      digits_nxt     = '0;
      enter_ok       = 1'b1;
      last_press_nxt = item.now_time;
    end
  end

  // Digit index DIGITS-1 holds the oldest digit, index 0 the newest.
  always_comb begin
    result.key_present    = hit.hit;
    result.key_code       = hit.hit ? hit.code : '0;
    result.digit_accepted = digit_ok;
    result.enter_accepted = enter_ok;
    result.entered_value  = enter_ok ? buffer_value(digits_r) : '0;
    result.current_code   = buffer_value(digits_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r     <= '0;
      last_press_r <= '0;
    end else if (step) begin
      digits_r     <= digits_nxt;
      last_press_r <= last_press_nxt;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(result.digit_accepted && result.enter_accepted))
    else $error("digit and enter accepted together");

  a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.enter_accepted |-> result.current_code == '0)
    else $error("enter did not clear the buffer");

  a_press_time: assert property (@(posedge clk) disable iff (!rst_n)
    step && (result.digit_accepted || result.enter_accepted)
      |=> last_press_r == $past(item.now_time))
    else $error("last press time not updated");

  a_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    step && (result.digit_accepted || result.enter_accepted)
      |-> timely && result.key_present)
    else $error("press accepted without a timely key");

endmodule

[tb/keypad_entry_checker.sv]
module keypad_entry_checker
  import kce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    pending
);

  localparam int unsigned RADIX = 10;
  localparam logic [CODE_W-1:0] KEY_CODES [16] = '{
    4'h1, 4'h2, 4'h3, 4'hA, 4'h4, 4'h5, 4'h6, 4'hB,
    4'h7, 4'h8, 4'h9, 4'hC, 4'hE, 4'h0, 4'hF, 4'hD
  };

  logic [TIME_W-1:0]  lockout;
  logic [CODE_W-1:0]  enter_code;
  logic [TIME_W-1:0]  last_press;
  logic [DIGIT_W-1:0] digits [DIGITS];
  result_t            expected_results [$];
  int                 result_index;

  function automatic logic [VALUE_W-1:0] decimal_value();
    int unsigned v;
    v = 0;
    for (int i = 0; i < DIGITS; i++) begin
      v = v * RADIX + digits[i];
    end
    return VALUE_W'(v);
  endfunction

  function automatic result_t predict_keypress(input in_item_t sample);
    result_t           r;
    logic              found;
    logic [CODE_W-1:0] code;
    logic [3:0]        cols;
    logic [TIME_W-1:0] elapsed;
    logic              timely;
    found = 1'b0;
    code  = '0;
    for (int row = 0; row < 4; row++) begin
      cols = sample.key_matrix[4*row +: 4];
      if (!found && cols != 4'h0) begin
        found = 1'b1;
        for (int col = 0; col < 4; col++) begin
          if (cols[col]) begin
            code = KEY_CODES[4*row+col];
          end
        end
      end
    end
    elapsed = sample.now_time - last_press;
    timely  = elapsed > lockout;
    r = '0;
    r.key_present = found;
    r.key_code    = code;
    if (found && code < CODE_W'(RADIX) && timely) begin
      // An enter code that is also a digit only restarts the lockout.
      if (code != enter_code) begin
        for (int i = 0; i < DIGITS - 1; i++) begin
          digits[i] = digits[i+1];
        end
        digits[DIGITS-1] = code;
        r.digit_accepted = 1'b1;
      end
      last_press = sample.now_time;
    end else if (found && code == enter_code && timely) begin
      r.entered_value = decimal_value();
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] = '0;
      end
      r.enter_accepted = 1'b1;
      last_press = sample.now_time;
    end
    r.current_code = decimal_value();
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("result %0d field %s: got %0h, expected %0h",
                       result_index, name, got, want));
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    result_t got;
    result_t want;
    got = data[$bits(result_t)-1:0];
    if (expected_results.size() == 0) begin
      report($sformatf("result %0d arrived with no request outstanding", result_index));
    end else begin
      want = expected_results.pop_front();
      compare_field("key_present", 32'(got.key_present), 32'(want.key_present));
      compare_field("key_code", 32'(got.key_code), 32'(want.key_code));
      compare_field("digit_accepted", 32'(got.digit_accepted), 32'(want.digit_accepted));
      compare_field("enter_accepted", 32'(got.enter_accepted), 32'(want.enter_accepted));
      compare_field("entered_value", 32'(got.entered_value), 32'(want.entered_value));
      compare_field("current_code", 32'(got.current_code), 32'(want.current_code));
      compare_field("padding", 32'(data[OUT_DATA_W-1:$bits(result_t)]), 32'd0);
    end
    result_index++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lockout    = LOCKOUT_RESET;
      enter_code = ENTER_RESET;
      last_press = '0;
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LOCKOUT) begin
          lockout = cfg_data[TIME_W-1:0];
        end else if (cfg_index == REG_ENTER) begin
          enter_code = cfg_data[CODE_W-1:0];
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_keypress(in_item_t'(in_tdata)));
      end
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  import kce_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int PHASE_REQUESTS = 156;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    error_count;
  int                    pending;
  int                    send_idle_pct;
  int                    stall_pct;
  logic [TIME_W-1:0]     tick_now;
  logic [TIME_W-1:0]     lockout_now;
  logic [3:0]            enter_pos;

  keypad_code_entry dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  keypad_entry_checker u_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_tready = $urandom_range(0, 99) >= stall_pct;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 56;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 56;
      end
      default: begin
        send_idle_pct = 7;
        stall_pct     = 7;
      end
    endcase
  endtask

  task automatic press(input logic [MATRIX_W-1:0] matrix, input logic [TIME_W-1:0] stamp);
    in_item_t item;
    item.key_matrix = matrix;
    item.now_time   = stamp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only once every outstanding result has come back.
  task automatic set_registers(input logic [TIME_W-1:0] lockout, input logic [CODE_W-1:0] enter);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = REG_LOCKOUT;
    cfg_data  = CFG_DATA_W'(lockout);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index = REG_ENTER;
    cfg_data  = CFG_DATA_W'(enter);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [MATRIX_W-1:0] pick_matrix();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end else if (r < 25) begin
      return MATRIX_W'(1) << enter_pos;
    end else if (r < 75) begin
      return MATRIX_W'(1) << $urandom_range(0, 15);
    end else if (r < 88) begin
      return MATRIX_W'($urandom);
    end else begin
      return MATRIX_W'($urandom & $urandom);
    end
  endfunction

  // Most steps land just past or right at the lockout so both outcomes occur.
  function automatic logic [TIME_W-1:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return lockout_now + TIME_W'(1) + TIME_W'($urandom_range(0, 2));
    end else if (r < 60) begin
      return lockout_now;
    end else if (r < 80) begin
      return TIME_W'($urandom_range(0, 15));
    end else if (r < 90) begin
      return '0;
    end else begin
      return TIME_W'($urandom);
    end
  endfunction

  task automatic run_phase(input logic [TIME_W-1:0] lockout, input logic [CODE_W-1:0] enter,
                           input logic [3:0] pos, input int first_mode);
    set_registers(lockout, enter);
    lockout_now = lockout;
    enter_pos   = pos;
    for (int chunk = 0; chunk < 4; chunk++) begin
      set_idling(idle_mode_e'((chunk + first_mode) % 4));
      repeat (PHASE_REQUESTS / 4) begin
        tick_now = tick_now + pick_step();
        press(pick_matrix(), tick_now);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LOCKOUT;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    tick_now      = '0;
    lockout_now   = LOCKOUT_RESET;
    enter_pos     = 4'd14;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests run with the register values left by reset.
    press(16'h0000, 32'd0);
    press(16'h0001, 32'd100);
    press(16'h0001, 32'd250);
    press(16'h0001, 32'd251);
    press(16'hFFFF, 32'd600);
    press(16'hFFF0, 32'd900);
    press(16'h4000, 32'd1200);
    press(16'h4000, 32'd1300);
    press(16'h2000, 32'd1500);
    press(16'h0400, 32'd1800);
    press(16'h0010, 32'd2100);
    press(16'h0200, 32'd2400);
    press(16'h0040, 32'd2700);
    press(16'h1000, 32'd3000);
    press(16'h8000, 32'd3300);
    press(16'h0800, 32'd3600);
    press(16'h8001, 32'd3900);
    press(16'h0100, 32'd4100);
    press(16'h4000, 32'hFFFF_FF00);
    press(16'h4000, 32'h0000_0010);
    press(16'h0002, 32'h0000_0100);
    press(16'h0004, 32'h0000_010B);
    press(16'h0000, 32'hFFFF_FFFF);

    tick_now = $urandom;
    run_phase(LOCKOUT_RESET, ENTER_RESET, 4'd14, 0);
    run_phase(32'd0, 4'hA, 4'd3, 1);
    run_phase(32'hFFFF_FFFF, 4'hE, 4'd12, 2);
    run_phase(32'hFFFF_FFFE, 4'hD, 4'd15, 3);
    run_phase(32'd1000, 4'h5, 4'd5, 0);
    run_phase(32'd37, 4'h0, 4'd13, 1);
    run_phase(TIME_W'($urandom_range(1, 5000)), 4'hB, 4'd7, 2);
    in_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/kce_pkg.sv
rtl/core/kce_engine.sv
rtl/core/keypad_code_entry.sv
tb/keypad_entry_checker.sv
tb/tb_top.sv
